FILE: rtl/vtsc_pkg.sv
// Shared types and constants for the voice triggered sample capture unit.
// No dependencies; imported by every module of the block.
package vtsc_pkg;

  // sample and counter widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 7;
  localparam int unsigned QuietW  = 8;
  localparam int unsigned ChunkW  = 13;
  localparam int unsigned CountW  = 20;
  localparam int unsigned IndexW  = 19;
  localparam int unsigned SumW    = 28;
  localparam int unsigned CfgW    = 20;

  // register reset values
  localparam logic [SampleW-1:0] ThresholdRst = 16'd400;
  localparam logic [GainW-1:0]   GainRst      = 7'd16;
  localparam logic [QuietW-1:0]  QuietRst     = 8'd62;
  localparam logic [ChunkW-1:0]  ChunkLenRst  = 13'd512;
  localparam logic [CountW-1:0]  MaxCaptRst   = 20'd480000;

  // saturation limits
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_THRESHOLD   = 3'd0,
    CFG_GAIN        = 3'd1,
    CFG_QUIET_LIMIT = 3'd2,
    CFG_CHUNK_LEN   = 3'd3,
    CFG_MAX_CAPTURE = 3'd4
  } cfg_idx_e;

  // reason a capture session ended
  typedef enum logic [2:0] {
    CAUSE_NONE        = 3'd0,
    CAUSE_SILENCE     = 3'd1,
    CAUSE_FULL        = 3'd2,
    CAUSE_BUTTON_REC  = 3'd3,
    CAUSE_BUTTON_WAIT = 3'd4
  } cause_e;

  // clamped configuration seen by the chunk controller
  typedef struct packed {
    logic [SampleW-1:0] threshold;
    logic [QuietW-1:0]  quiet_limit;
    logic [ChunkW-1:0]  chunk_len;
    logic [CountW-1:0]  max_capture;
  } eff_cfg_t;

  // conditioned sample between the two stages
  typedef struct packed {
    logic                      valid;
    logic signed [SampleW-1:0] amp;
    logic [SampleW-1:0]        mag;
    logic                      stop;
  } cond_t;

endpackage

FILE: rtl/vtsc_condition.sv
// Input register, DC tracking, gain and saturation stage.
// Depends on vtsc_pkg for widths, limits and the cond_t stage record.
module vtsc_condition import vtsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_in_i,
  input  logic               en_mid_i,
  input  logic               in_valid_i,
  input  logic [31:0]        raw_word_i,
  input  logic               stop_button_i,
  input  logic [GainW-1:0]   gain_i,
  output logic               in_occupied_o,
  output cond_t              cond_o
);

  logic                      v1_q;
  logic signed [SampleW-1:0] x_q;
  logic                      stop1_q;
  logic signed [SampleW-1:0] dc_q;
  logic signed [SampleW-1:0] dc_d;
  cond_t                     mid_q;
  cond_t                     mid_d;

  logic signed [21:0]        acc;
  logic signed [21:0]        acc_rnd;
  logic signed [SampleW-1:0] diff;
  logic signed [23:0]        prod;
  logic signed [SampleW:0]   amp_ext;

  // dc = (dc*31 + x)/32 truncated toward zero, then gain and saturation
  always_comb begin
    acc     = ({{6{dc_q[SampleW-1]}}, dc_q} <<< 5) - {{6{dc_q[SampleW-1]}}, dc_q}
            + {{6{x_q[SampleW-1]}}, x_q};
    acc_rnd = acc[21] ? (acc + 22'sd31) : acc;
    dc_d    = SampleW'(acc_rnd >>> 5);
    diff    = x_q - dc_d;
    prod    = diff * $signed({1'b0, gain_i});
    mid_d.valid = v1_q;
    mid_d.stop  = stop1_q;
    if (prod > 24'(SampleMax)) begin
      mid_d.amp = SampleMax;
    end else if (prod < 24'(SampleMin)) begin
      mid_d.amp = SampleMin;
    end else begin
      mid_d.amp = SampleW'(prod);
    end
    amp_ext   = {mid_d.amp[SampleW-1], mid_d.amp};
    mid_d.mag = amp_ext[SampleW] ? SampleW'(-amp_ext) : SampleW'(amp_ext);
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_in_i) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_in_i && in_valid_i) begin
      x_q     <= raw_word_i[31:16];
      stop1_q <= stop_button_i;
    end
  end

  // dc estimate moves once per transfer into the middle register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q  <= '0;
      mid_q <= '0;
    end else if (en_mid_i) begin
      mid_q <= mid_d;
      if (v1_q) begin
        dc_q <= dc_d;
      end
    end
  end

  assign in_occupied_o = v1_q;
  assign cond_o        = mid_q;

endmodule

FILE: rtl/vtsc_chunk_ctrl.sv
// Chunk level detector, capture session control and result register.
// Depends on vtsc_pkg for eff_cfg_t, cond_t and the finish cause codes.
module vtsc_chunk_ctrl import vtsc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_out_i,
  input  eff_cfg_t                  cfg_i,
  input  cond_t                     s_i,
  output logic                      out_valid_o,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic [IndexW-1:0]         sample_index_o,
  output logic                      recording_phase_o,
  output logic                      chunk_done_o,
  output logic                      chunk_loud_o,
  output logic                      capture_finished_o,
  output logic [2:0]                finish_cause_o,
  output logic [CountW-1:0]         captured_count_o
);

  typedef enum logic {
    PH_WAIT = 1'b0,
    PH_REC  = 1'b1
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [ChunkW-1:0]   pos_q, pos_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [CountW-1:0]   cap_q, cap_d;
  logic [QuietW-1:0]   quiet_q, quiet_d;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] amp_q;
  logic [IndexW-1:0]         index_q, index_d;
  logic                      rec_q;
  logic                      done_q, done_d;
  logic                      loud_q, loud_d;
  logic                      fin_q, fin_d;
  cause_e                    cause_q, cause_d;
  logic [CountW-1:0]         cnt_q, cnt_d;

  logic [SumW-1:0]     sum_add;
  logic [ChunkW-1:0]   count;
  logic [SumW:0]       thr_prod;
  logic                loud_c;
  logic [CountW-1:0]   cap_inc;
  logic [QuietW-1:0]   quiet_inc;
  logic                chunk_end;

  // next state of the chunk and session counters
  always_comb begin
    sum_add   = sum_q + SumW'(s_i.mag);
    count     = pos_q + 1'b1;
    thr_prod  = (SumW+1)'(cfg_i.threshold) * (SumW+1)'(count);
    loud_c    = ({1'b0, sum_add} >= thr_prod);
    cap_inc   = cap_q + 1'b1;
    quiet_inc = quiet_q + 1'b1;
    chunk_end = (count >= cfg_i.chunk_len);

    phase_d = phase_q;
    pos_d   = count;
    sum_d   = sum_add;
    cap_d   = cap_q;
    quiet_d = quiet_q;
    index_d = {{(IndexW-ChunkW){1'b0}}, pos_q};
    done_d  = 1'b0;
    loud_d  = 1'b0;
    fin_d   = 1'b0;
    cause_d = CAUSE_NONE;
    cnt_d   = '0;

    unique case (phase_q)
      PH_WAIT: begin
        if (chunk_end) begin
          done_d = 1'b1;
          loud_d = loud_c;
          pos_d  = '0;
          sum_d  = '0;
          if (loud_c) begin
            // loud chunk opens a recording that keeps this chunk
            phase_d = PH_REC;
            cap_d   = CountW'(count);
            quiet_d = '0;
            if (CountW'(count) >= cfg_i.max_capture) begin
              fin_d   = 1'b1;
              cause_d = CAUSE_FULL;
              cnt_d   = CountW'(count);
            end
          end else if (s_i.stop) begin
            fin_d   = 1'b1;
            cause_d = CAUSE_BUTTON_WAIT;
          end
        end
      end
      PH_REC: begin
        index_d = cap_q[IndexW-1:0];
        cap_d   = cap_inc;
        if (chunk_end || (cap_inc >= cfg_i.max_capture)) begin
          done_d = 1'b1;
          loud_d = loud_c;
          pos_d  = '0;
          sum_d  = '0;
          // button first, then silence, then full buffer
          priority if (s_i.stop) begin
            fin_d   = 1'b1;
            cause_d = CAUSE_BUTTON_REC;
          end else if (loud_c) begin
            quiet_d = '0;
          end else begin
            quiet_d = quiet_inc;
            if (quiet_inc >= cfg_i.quiet_limit) begin
              fin_d   = 1'b1;
              cause_d = CAUSE_SILENCE;
            end
          end
          if (!fin_d && (cap_inc >= cfg_i.max_capture)) begin
            fin_d   = 1'b1;
            cause_d = CAUSE_FULL;
          end
          if (fin_d) begin
            cnt_d = cap_inc;
          end
        end
      end
      default: begin
        phase_d = PH_WAIT;
      end
    endcase

    // session end returns to waiting; dc estimate is kept upstream
    if (fin_d) begin
      phase_d = PH_WAIT;
      pos_d   = '0;
      sum_d   = '0;
      cap_d   = '0;
      quiet_d = '0;
    end
  end

  // session state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      pos_q       <= '0;
      sum_q       <= '0;
      cap_q       <= '0;
      quiet_q     <= '0;
      out_valid_q <= 1'b0;
      amp_q       <= '0;
      index_q     <= '0;
      rec_q       <= 1'b0;
      done_q      <= 1'b0;
      loud_q      <= 1'b0;
      fin_q       <= 1'b0;
      cause_q     <= CAUSE_NONE;
      cnt_q       <= '0;
    end else if (en_out_i) begin
      out_valid_q <= s_i.valid;
      if (s_i.valid) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        sum_q   <= sum_d;
        cap_q   <= cap_d;
        quiet_q <= quiet_d;
        amp_q   <= s_i.amp;
        index_q <= index_d;
        rec_q   <= (phase_q == PH_REC);
        done_q  <= done_d;
        loud_q  <= loud_d;
        fin_q   <= fin_d;
        cause_q <= cause_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sample_out_o       = amp_q;
  assign sample_index_o     = index_q;
  assign recording_phase_o  = rec_q;
  assign chunk_done_o       = done_q;
  assign chunk_loud_o       = loud_q;
  assign capture_finished_o = fin_q;
  assign finish_cause_o     = cause_q;
  assign captured_count_o   = cnt_q;

  // a session only ends on a chunk boundary
  a_fin_on_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && fin_q |-> done_q)
    else $error("capture finished outside a chunk end");

  // cause code agrees with the finish flag
  a_cause_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (fin_q == (cause_q != CAUSE_NONE)))
    else $error("finish cause does not match finish flag");

  // loud flag only on a closed chunk
  a_loud_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && loud_q |-> done_q)
    else $error("chunk loud without chunk end");

  // waiting phase never holds captured samples
  a_wait_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WAIT |-> cap_q == '0)
    else $error("captured count nonzero while waiting");

  // a finished session leaves the controller idle and empty
  a_fin_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_out_i && s_i.valid && fin_d |=> phase_q == PH_WAIT && pos_q == '0 && quiet_q == '0)
    else $error("session state not cleared after finish");

endmodule

FILE: rtl/voice_triggered_sample_capture_unit.sv
// A sample accepted at the input passes the input, middle and result registers in that order.
// One sample per cycle while the result is not stalled; the chunk controller closes its state loop each cycle.
// A stalled result holds while the input and middle registers keep filling.
// Reset (asynchronous, active low) clears the DC estimate, the session state and all
// valid flags, and loads the registers with their documented default values.
module voice_triggered_sample_capture_unit import vtsc_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 524288,
  parameter int unsigned CHUNK_MAX    = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // sample input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [31:0]               raw_word_i,
  input  logic                      stop_button_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic [IndexW-1:0]         sample_index_o,
  output logic                      recording_phase_o,
  output logic                      chunk_done_o,
  output logic                      chunk_loud_o,
  output logic                      capture_finished_o,
  output logic [2:0]                finish_cause_o,
  output logic [CountW-1:0]         captured_count_o,
  // register writes
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [CfgW-1:0]           cfg_data_i
);

  localparam logic [CountW:0] BufDepthW = (CountW+1)'(BUFFER_DEPTH);
  localparam logic [16:0]     ChunkMaxW = 17'(CHUNK_MAX);

  logic [SampleW-1:0] threshold_q;
  logic [GainW-1:0]   gain_q;
  logic [QuietW-1:0]  quiet_q;
  logic [ChunkW-1:0]  chunk_len_q;
  logic [CountW-1:0]  max_capt_q;

  eff_cfg_t           eff_cfg;
  logic [ChunkW-1:0]  clen_lo;
  logic [ChunkW-1:0]  clen_cm;

  logic   en_in, en_mid, en_out;
  logic   in_occupied;
  cond_t  cond;

  // register writes, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      gain_q      <= GainRst;
      quiet_q     <= QuietRst;
      chunk_len_q <= ChunkLenRst;
      max_capt_q  <= MaxCaptRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:   threshold_q <= cfg_data_i[SampleW-1:0];
        CFG_GAIN:        gain_q      <= cfg_data_i[GainW-1:0];
        CFG_QUIET_LIMIT: quiet_q     <= cfg_data_i[QuietW-1:0];
        CFG_CHUNK_LEN:   chunk_len_q <= cfg_data_i[ChunkW-1:0];
        CFG_MAX_CAPTURE: max_capt_q  <= cfg_data_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp capture and chunk lengths to their legal ranges
  always_comb begin
    if (max_capt_q == '0) begin
      eff_cfg.max_capture = CountW'(1);
    end else if ({1'b0, max_capt_q} > BufDepthW) begin
      eff_cfg.max_capture = BufDepthW[CountW-1:0];
    end else begin
      eff_cfg.max_capture = max_capt_q;
    end
    clen_lo = (chunk_len_q == '0) ? ChunkW'(1) : chunk_len_q;
    clen_cm = ({4'b0, clen_lo} > ChunkMaxW) ? ChunkMaxW[ChunkW-1:0] : clen_lo;
    if ({{(CountW-ChunkW){1'b0}}, clen_cm} > eff_cfg.max_capture) begin
      eff_cfg.chunk_len = eff_cfg.max_capture[ChunkW-1:0];
    end else begin
      eff_cfg.chunk_len = clen_cm;
    end
    eff_cfg.threshold   = threshold_q;
    eff_cfg.quiet_limit = quiet_q;
  end

  // pipeline advance: a stage moves when empty or when its successor moves
  assign en_out     = !out_valid_o || !out_stall_i;
  assign en_mid     = !cond.valid || en_out;
  assign en_in      = !in_occupied || en_mid;
  assign in_stall_o = !en_in;

  vtsc_condition u_condition (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_in_i       (en_in),
    .en_mid_i      (en_mid),
    .in_valid_i    (in_valid_i),
    .raw_word_i    (raw_word_i),
    .stop_button_i (stop_button_i),
    .gain_i        (gain_q),
    .in_occupied_o (in_occupied),
    .cond_o        (cond)
  );

  vtsc_chunk_ctrl u_chunk_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .en_out_i           (en_out),
    .cfg_i              (eff_cfg),
    .s_i                (cond),
    .out_valid_o        (out_valid_o),
    .sample_out_o       (sample_out_o),
    .sample_index_o     (sample_index_o),
    .recording_phase_o  (recording_phase_o),
    .chunk_done_o       (chunk_done_o),
    .chunk_loud_o       (chunk_loud_o),
    .capture_finished_o (capture_finished_o),
    .finish_cause_o     (finish_cause_o),
    .captured_count_o   (captured_count_o)
  );

endmodule
